// ----- hw/rtl/pps_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int unsigned TagWidth        = 8;
  localparam int unsigned FieldWidth      = 16;
  localparam int unsigned SlotsDefault    = 16;
  localparam int unsigned TimeBitsDefault = 16;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [1:0] {
    PPS_IDLE,
    PPS_SCAN,
    PPS_DONE
  } pps_state_e;

  typedef struct packed {
    logic                  operation;
    logic [TagWidth-1:0]   process_tag;
    logic [FieldWidth-1:0] arrival_time;
    logic [FieldWidth-1:0] burst_length;
    logic [FieldWidth-1:0] priority_level;
  } in_word_t;

  typedef struct packed {
    logic                  idle;
    logic [TagWidth-1:0]   run_tag;
    logic                  finished;
    logic [FieldWidth-1:0] completion_time;
    logic [FieldWidth-1:0] turnaround_time;
    logic [FieldWidth-1:0] waiting_time;
    logic                  all_done;
  } out_word_t;

  // Best candidate so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic                  found;
    logic [TagWidth-1:0]   tag;
    logic [FieldWidth-1:0] arrival;
    logic [FieldWidth-1:0] burst;
    logic [FieldWidth-1:0] remaining;
    logic [FieldWidth-1:0] prio;
  } token_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pps_if.sv -----
// Handshake interfaces for the scheduler: input word channel and result channel.
// Depends on pps_pkg for the word types.
`timescale 1ns / 1ps
`default_nettype none

interface pps_in_if;
  import pps_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface pps_out_if;
  import pps_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pps_cell.sv -----
// One slot of the scheduler table with its link of the candidate chain.
// Depends on pps_pkg for the token type and field widths.
`timescale 1ns / 1ps
`default_nettype none

module pps_cell #(
  parameter int unsigned TIME_BITS = pps_pkg::TimeBitsDefault,
  parameter int unsigned IDX_BITS  = 4,
  parameter int unsigned CELL_ID   = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [TIME_BITS-1:0] cur_time_i,
  input  wire logic                 loaded_i,
  input  wire logic                 wr_en_i,
  input  wire pps_pkg::in_word_t    wr_word_i,
  input  wire logic                 dec_en_i,
  input  wire pps_pkg::token_t      tok_i,
  input  wire logic [IDX_BITS-1:0]  slot_i,
  output pps_pkg::token_t           tok_o,
  output logic      [IDX_BITS-1:0]  slot_o
);
  import pps_pkg::*;

  localparam int unsigned TW = (TIME_BITS > FieldWidth) ? TIME_BITS : FieldWidth;

  logic [TagWidth-1:0]   tag_q;
  logic [FieldWidth-1:0] arrival_q, burst_q, remaining_q, prio_q;
  logic                  eligible, better;
  logic                  found_d, found_q;
  token_t                tok_d, tok_q;
  logic [IDX_BITS-1:0]   slot_d, slot_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_q       <= wr_word_i.process_tag;
      arrival_q   <= wr_word_i.arrival_time;
      burst_q     <= wr_word_i.burst_length;
      remaining_q <= wr_word_i.burst_length;
      prio_q      <= wr_word_i.priority_level;
    end else if (dec_en_i) begin
      remaining_q <= remaining_q - 1'b1;
    end
  end

  always_comb begin
    eligible = loaded_i && (remaining_q != '0) &&
               (TW'(arrival_q) <= TW'(cur_time_i));
    // keep the incoming candidate on a full tie: it sits in a lower slot
    better = eligible && (!tok_i.found || (prio_q < tok_i.prio) ||
             ((prio_q == tok_i.prio) && (arrival_q < tok_i.arrival)));
    found_d = better || tok_i.found;
    if (better) begin
      tok_d.found     = 1'b1;
      tok_d.tag       = tag_q;
      tok_d.arrival   = arrival_q;
      tok_d.burst     = burst_q;
      tok_d.remaining = remaining_q;
      tok_d.prio      = prio_q;
      slot_d          = IDX_BITS'(CELL_ID);
    end else begin
      tok_d  = tok_i;
      slot_d = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    slot_q <= slot_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.found = found_q;
    slot_o      = slot_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/preemptive_priority_scheduler_core.sv -----
// Top level of the preemptive priority scheduler: control, clock of ticks, result register.
// Depends on pps_pkg, pps_if (pps_in_if, pps_out_if) and pps_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Interface    Word
// in_i      in   pps_in_if    operation, process_tag, arrival_time, burst_length, priority_level
// out_o     out  pps_out_if   idle, run_tag, finished, completion, turnaround, waiting, all_done
//
// A load word yields no result. A tick word is accepted, the candidate token then ripples
// down the chain of slot cells (one cell per cycle), and the winner is then committed and
// the result register written. The commit stalls while the result register holds a word
// not yet taken; loads and the acceptance of further words are not blocked by a waiting
// result except at commit. Reset clears time, counts, control state and the result valid
// flag; slot contents are left as they are and only slots below the load count are ever
// looked at.

module preemptive_priority_scheduler_core #(
  parameter int unsigned SLOTS     = pps_pkg::SlotsDefault,
  parameter int unsigned TIME_BITS = pps_pkg::TimeBitsDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pps_in_if.sink   in_i,
  pps_out_if.source out_o
);
  import pps_pkg::*;

  localparam int unsigned IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_BITS = $clog2(SLOTS + 1);
  localparam int unsigned TW       = (TIME_BITS > FieldWidth) ? TIME_BITS : FieldWidth;
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  pps_state_e state_q, state_d;
  logic [IDX_BITS-1:0]  scan_cnt_q, scan_cnt_d;
  logic [TIME_BITS-1:0] cur_time_q, cur_time_d, time_next;
  logic [CNT_BITS-1:0]  loaded_q, loaded_d, finished_q, finished_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q, out_word_d;

  logic                 accept, do_load, commit, done_now;
  logic [SLOTS-1:0]     loaded_vec, wr_vec, dec_vec;
  token_t               tok   [SLOTS+1];
  logic [IDX_BITS-1:0]  slot  [SLOTS+1];
  token_t               win;
  logic [TW-1:0]        compl_ext, turn_ext, burst_ext;

  assign accept   = in_i.valid && in_i.ready;
  assign do_load  = accept && (in_i.word.operation == OpLoad) &&
                    (loaded_q != CNT_BITS'(SLOTS));
  assign in_i.ready = (state_q == PPS_IDLE);

  // head of the chain: no candidate yet
  assign tok[0]  = '0;
  assign slot[0] = '0;
  assign win     = tok[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign loaded_vec[i] = (CNT_BITS'(i) < loaded_q);
    assign wr_vec[i]     = do_load && (loaded_q == CNT_BITS'(i));
    assign dec_vec[i]    = commit && win.found && (slot[SLOTS] == IDX_BITS'(i));

    pps_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_BITS  (IDX_BITS),
      .CELL_ID   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cur_time_i (cur_time_q),
      .loaded_i   (loaded_vec[i]),
      .wr_en_i    (wr_vec[i]),
      .wr_word_i  (in_i.word),
      .dec_en_i   (dec_vec[i]),
      .tok_i      (tok[i]),
      .slot_i     (slot[i]),
      .tok_o      (tok[i+1]),
      .slot_o     (slot[i+1])
    );
  end

  // saturating clock of ticks
  assign time_next = (cur_time_q == TimeMax) ? cur_time_q : cur_time_q + 1'b1;

  always_comb begin
    compl_ext = TW'(time_next);
    burst_ext = TW'(win.burst);
    turn_ext  = compl_ext - TW'(win.arrival);
    done_now  = win.found && (win.remaining == FieldWidth'(1));
  end

  always_comb begin
    state_d     = state_q;
    scan_cnt_d  = scan_cnt_q;
    cur_time_d  = cur_time_q;
    loaded_d    = loaded_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    commit      = 1'b0;

    // drop the result word once it is taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      PPS_IDLE: begin
        if (accept) begin
          if (in_i.word.operation == OpTick) begin
            state_d    = PPS_SCAN;
            scan_cnt_d = '0;
          end else if (do_load) begin
            loaded_d = loaded_q + 1'b1;
            // a process with no burst counts as finished at once
            if (in_i.word.burst_length == '0) begin
              finished_d = finished_q + 1'b1;
            end
          end
        end
      end
      PPS_SCAN: begin
        scan_cnt_d = scan_cnt_q + 1'b1;
        if (scan_cnt_q == IDX_BITS'(SLOTS - 1)) begin
          state_d = PPS_DONE;
        end
      end
      PPS_DONE: begin
        // hold the winner until the result register is free
        if (!out_valid_q || out_o.ready) begin
          commit     = 1'b1;
          state_d    = PPS_IDLE;
          cur_time_d = time_next;
          if (done_now) begin
            finished_d = finished_q + 1'b1;
          end
          out_valid_d                = 1'b1;
          out_word_d                 = '0;
          out_word_d.idle            = !win.found;
          out_word_d.run_tag         = win.found ? win.tag : '0;
          out_word_d.finished        = done_now;
          if (done_now) begin
            out_word_d.completion_time = compl_ext[FieldWidth-1:0];
            out_word_d.turnaround_time = turn_ext[FieldWidth-1:0];
            out_word_d.waiting_time    = (turn_ext >= burst_ext) ?
                                         FieldWidth'(turn_ext - burst_ext) : '0;
          end
          out_word_d.all_done = (finished_d == loaded_q);
        end
      end
      default: begin
        state_d = PPS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PPS_IDLE;
      scan_cnt_q  <= '0;
      cur_time_q  <= '0;
      loaded_q    <= '0;
      finished_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      cur_time_q  <= cur_time_d;
      loaded_q    <= loaded_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  // table never overfills and never reports more finished than loaded
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loaded_q <= CNT_BITS'(SLOTS)) && (finished_q <= loaded_q))
    else $error("slot counts out of range");

  // time only moves forward, and only on a commit
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> (cur_time_q == $past(cur_time_q)))
    else $error("time moved without a tick");

  // a commit always leaves a fresh result word behind
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("tick committed without a result");

  // a completion is never reported on an idle tick
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.finished && out_word_q.idle))
    else $error("finished reported on idle tick");

  // no new word is taken while a tick is in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PPS_SCAN || state_q == PPS_DONE) |-> !accept)
    else $error("word accepted during a tick");

endmodule

`default_nettype wire

// ----- dv/pps_schedule_checker.sv -----
// Checker for the preemptive priority scheduler: watches both word channels, keeps a slot
// table of its own, predicts every tick result and compares it field by field.
// Depends on pps_pkg and pps_if.
`timescale 1ns / 1ps

module pps_schedule_checker #(
  parameter int unsigned SLOTS     = pps_pkg::SlotsDefault,
  parameter int unsigned TIME_BITS = pps_pkg::TimeBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  pps_in_if    in_mon,
  pps_out_if   out_mon,
  output int   fail_count_o,
  output int   results_seen_o,
  output int   pending_o
);
  import pps_pkg::*;

  localparam logic [31:0] TimeMax = 32'((64'd1 << TIME_BITS) - 64'd1);

  logic [TagWidth-1:0]   tag_q   [SLOTS];
  logic [FieldWidth-1:0] arr_q   [SLOTS];
  logic [FieldWidth-1:0] burst_q [SLOTS];
  logic [FieldWidth-1:0] left_q  [SLOTS];
  logic [FieldWidth-1:0] prio_q  [SLOTS];
  logic [31:0]           now_t;
  int                    loaded_n;
  int                    finished_n;
  int                    mismatches;
  int                    seen_n;
  out_word_t             tick_results_q[$];

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_word_t   want;
    out_word_t   got;
    int          pick;
    bit          found;
    logic [31:0] next_t;
    logic [31:0] tat;
    if (!rst_ni) begin
      now_t          = '0;
      loaded_n       = 0;
      finished_n     = 0;
      mismatches     = 0;
      seen_n         = 0;
      tick_results_q.delete();
      fail_count_o   <= 0;
      results_seen_o <= 0;
      pending_o      <= 0;
    end else begin
      // Retire the result word first; it always belongs to an older tick.
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.word;
        seen_n++;
        if (tick_results_q.size() == 0) begin
          $display("%0t: result word with none expected, actual idle=%0d tag=%0h fin=%0d",
                   $time, got.idle, got.run_tag, got.finished);
          mismatches++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("idle", 32'(want.idle), 32'(got.idle));
          check_field("run_tag", 32'(want.run_tag), 32'(got.run_tag));
          check_field("finished", 32'(want.finished), 32'(got.finished));
          check_field("completion_time", 32'(want.completion_time),
                      32'(got.completion_time));
          check_field("turnaround_time", 32'(want.turnaround_time),
                      32'(got.turnaround_time));
          check_field("waiting_time", 32'(want.waiting_time), 32'(got.waiting_time));
          check_field("all_done", 32'(want.all_done), 32'(got.all_done));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.word.operation == OpLoad) begin
          // Drop loads into a full table.
          if (loaded_n < SLOTS) begin
            tag_q[loaded_n]   = in_mon.word.process_tag;
            arr_q[loaded_n]   = in_mon.word.arrival_time;
            burst_q[loaded_n] = in_mon.word.burst_length;
            left_q[loaded_n]  = in_mon.word.burst_length;
            prio_q[loaded_n]  = in_mon.word.priority_level;
            if (in_mon.word.burst_length == '0) finished_n++;
            loaded_n++;
          end
        end else begin
          found = 1'b0;
          pick  = 0;
          for (int i = 0; i < loaded_n; i++) begin
            if (left_q[i] == '0 || 32'(arr_q[i]) > now_t) continue;
            if (!found || prio_q[i] < prio_q[pick] ||
                (prio_q[i] == prio_q[pick] && arr_q[i] < arr_q[pick])) begin
              pick  = i;
              found = 1'b1;
            end
          end
          want      = '0;
          want.idle = !found;
          next_t    = (now_t >= TimeMax) ? TimeMax : now_t + 32'd1;
          if (found) begin
            want.run_tag = tag_q[pick];
            left_q[pick] = left_q[pick] - 1'b1;
            if (left_q[pick] == '0) begin
              finished_n++;
              tat                  = next_t - 32'(arr_q[pick]);
              want.finished        = 1'b1;
              want.completion_time = next_t[FieldWidth-1:0];
              want.turnaround_time = tat[FieldWidth-1:0];
              want.waiting_time    = (tat >= 32'(burst_q[pick])) ?
                                     FieldWidth'(tat - 32'(burst_q[pick])) : '0;
            end
          end
          now_t         = next_t;
          want.all_done = (finished_n == loaded_n);
          tick_results_q.push_back(want);
        end
      end

      fail_count_o   <= mismatches;
      results_seen_o <= seen_n;
      pending_o      <= tick_results_q.size();
    end
  end

endmodule

// ----- dv/preemptive_priority_scheduler_core_tb.sv -----
// Top of the scheduler testbench: clock, reset, word stimulus, result-side back-pressure
// and the verdict. Depends on pps_pkg, pps_if, the core and pps_schedule_checker.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_core_tb;
  import pps_pkg::*;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned TIME_BITS     = 16;
  // Long enough for the core to hold one result, stall at commit and block its input.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Settling time at the end of the run: a little over what a tick word needs.
  localparam int unsigned SETTLE_CYCLES = SLOTS + 4;
  // Run limit in ns, set several times over the slowest correct run.
  localparam int unsigned RunLimitNs    = 5_000_000;

  logic clk;
  logic rst_n;
  logic no_idle;     // both sides keep valid / ready high while set
  logic flood_on;    // receiver takes its long hold-off while set
  int   ticks_sent;  // accepted tick words, equal to the core's notion of time
  int   loads_sent;  // accepted load words, overflowing ones included
  int   fail_count;
  int   results_seen;
  int   pending;
  int   hold_cnt;
  bit   hold_spent;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  preemptive_priority_scheduler_core #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pps_schedule_checker #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) sched_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count_o   (fail_count),
    .results_seen_o (results_seen),
    .pending_o      (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #(RunLimitNs);
    $display("%0t: run limit reached", $time);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random back-pressure, none while no_idle is set, and one long hold-off
  // timed here while the sender floods the core with ticks.
  initial begin
    out_ch.ready <= 1'b0;
    hold_spent = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (flood_on && !hold_spent) begin
        out_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_spent = 1'b1;
      end else begin
        out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
      end
    end
  end

  function automatic in_word_t make_tick();
    in_word_t w;
    // Tick payload is ignored by the core; fill it with noise anyway.
    w.operation      = OpTick;
    w.process_tag    = TagWidth'($urandom);
    w.arrival_time   = FieldWidth'($urandom);
    w.burst_length   = FieldWidth'($urandom);
    w.priority_level = FieldWidth'($urandom);
    return w;
  endfunction

  function automatic in_word_t make_load(input logic [TagWidth-1:0] tag,
                                         input logic [FieldWidth-1:0] arr,
                                         input logic [FieldWidth-1:0] burst,
                                         input logic [FieldWidth-1:0] prio);
    in_word_t w;
    w.operation      = OpLoad;
    w.process_tag    = tag;
    w.arrival_time   = arr;
    w.burst_length   = burst;
    w.priority_level = prio;
    return w;
  endfunction

  // Well-formed process: arrives now or soon, mostly short bursts, priorities often
  // drawn from a tiny range so that ties on priority and arrival come up.
  function automatic in_word_t random_load();
    int arr;
    int burst;
    int prio;
    arr   = ($urandom_range(2) == 0) ? ticks_sent : ticks_sent + $urandom_range(1, 25);
    burst = ($urandom_range(3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    prio  = ($urandom_range(1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
    return make_load(TagWidth'($urandom), FieldWidth'(arr), FieldWidth'(burst),
                     FieldWidth'(prio));
  endfunction

  // Keep one slot spare for the never-ready process loaded after the pressure phase.
  function automatic in_word_t random_item();
    if (loads_sent < SLOTS - 1 && $urandom_range(4) == 0) return random_load();
    return make_tick();
  endfunction

  // Offer one word, idling beforehand at random unless told to push hard, and hold
  // it until the core takes it.
  task automatic send_word(input in_word_t w, input bit eager);
    if (!eager && !no_idle) begin
      while ($urandom_range(99) < 29) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.word  <= w;
    do @(posedge clk); while (!in_ch.ready);
    if (w.operation == OpTick) ticks_sent++;
    else loads_sent++;
  endtask

  // Drop valid and wait until every tick has produced its result word.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_seen < ticks_sent) @(posedge clk);
  endtask

  initial begin : stimulus
    in_ch.valid <= 1'b0;
    in_ch.word  <= '0;
    no_idle     <= 1'b0;
    flood_on    <= 1'b0;
    rst_n       <= 1'b0;
    ticks_sent  = 0;
    loads_sent  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Tick on an empty table: idle, and all done.
    send_word(make_tick(), 1'b0);
    // Process not yet arrived: the next tick is idle and time still advances.
    send_word(make_load(8'hFF, 16'd3, 16'd2, 16'd7), 1'b0);
    send_word(make_tick(), 1'b0);
    // Zero burst counts as finished at once and is never served.
    send_word(make_load(8'h00, 16'd0, 16'd0, 16'd0), 1'b0);
    send_word(make_tick(), 1'b0);
    // Same priority, later arrival: loses to slot 0.
    send_word(make_load(8'h11, 16'd4, 16'd2, 16'd7), 1'b0);
    // Same priority and arrival as slot 0: the lower slot wins.
    send_word(make_load(8'h22, 16'd3, 16'd1, 16'd7), 1'b0);
    // Most urgent, arrives exactly at the current time.
    send_word(make_load(8'h44, 16'd3, 16'd1, 16'd0), 1'b0);
    // Serve everything in priority order, then a few idle ticks with all done.
    repeat (9) send_word(make_tick(), 1'b0);
    drain();

    // Random part with ordinary idling on both sides.
    repeat (160) send_word(random_item(), 1'b0);

    // Stretch with no idling at all.
    no_idle <= 1'b1;
    repeat (100) send_word(random_item(), 1'b0);
    no_idle <= 1'b0;

    // Flood with ticks while the receiver holds off, then pause for every result.
    flood_on <= 1'b1;
    repeat (40) send_word(make_tick(), 1'b1);
    flood_on <= 1'b0;
    drain();

    // Fill the table; the last slot takes a process that can never become ready.
    while (loads_sent < SLOTS - 1) send_word(random_load(), 1'b0);
    send_word(make_load(8'hA5, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
    // Loads into a full table must be ignored.
    repeat (2) send_word(random_load(), 1'b0);

    // Remaining ticks; the odd overflowing load is thrown in as noise.
    for (int n = 0; n < 200; n++) begin
      if ($urandom_range(19) == 0) send_word(random_load(), 1'b0);
      send_word(make_tick(), 1'b0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
